// ----- rtl/plu_pkg.sv -----
// shared constants and types for the piecewise linear interpolator
// no dependencies; imported by plu_div, the top level and the checker

package plu_pkg;

    localparam int PLU_TABLE_DEPTH = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } plu_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } plu_div_rsp_t;

endpackage

// ----- rtl/plu_in_if.sv -----
// input channel of the interpolator: load or query items
// no dependencies

interface plu_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] point_time;
    logic signed [31:0] point_amplitude;

    modport source (output valid, output operation, output point_time,
                    output point_amplitude, input ready);
    modport sink   (input valid, input operation, input point_time,
                    input point_amplitude, output ready);
endinterface

// ----- rtl/plu_out_if.sv -----
// result channel of the interpolator
// no dependencies

interface plu_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] amplitude_out;
    logic [1:0]  status;

    modport source (output valid, output amplitude_out, output status, input ready);
    modport sink   (input valid, input amplitude_out, input status, output ready);
endinterface

// ----- rtl/plu_table.sv -----
// breakpoint store: one write port, one registered read port
// depends on nothing but its parameters

module plu_table #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/plu_div.sv -----
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// depends on plu_pkg; quotient assumed to fit in 32 bits

module plu_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plu_pkg::plu_div_req_t req,
    output plu_pkg::plu_div_rsp_t rsp
);
    import plu_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] dq_reg, dq_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        trial      = {rem_reg, dq_reg[63]};
        diff       = trial - {1'b0, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 6'd63;
            rem_next   = '0;
            dq_next    = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                dq_next  = {dq_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                dq_next  = {dq_reg[62:0], 1'b0};
            end
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg[31:0];

endmodule

// ----- rtl/piecewise_linear_interpolator_unit.sv -----
// piecewise linear interpolator: table store, search sequencer, divider
// depends on plu_pkg, plu_in_if, plu_out_if, plu_table, plu_div
// load: accept, then result; query: first and last entries checked for end points,
// else table walk, then multiply, divide and result
// one item at a time; ready again once the result is in the output register
// reset empties the table (count to zero); table contents are not cleared

module piecewise_linear_interpolator_unit #(
    parameter int TABLE_DEPTH = plu_pkg::PLU_TABLE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    plu_in_if.sink    req,
    plu_out_if.source rsp
);
    import plu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FIRST  = 7'b0000010,
        S_LAST   = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] qtime_reg, qtime_next;
    logic [31:0] prev_t_reg, prev_t_next;
    logic [31:0] prev_a_reg, prev_a_next;
    logic [31:0] mag_reg, mag_next;
    logic [31:0] dt_reg, dt_next;
    logic [31:0] dn_reg, dn_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_amp_reg, res_amp_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_amp_reg, out_amp_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic [31:0]   cur_t;
    logic [31:0]   cur_a;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;
    logic [32:0]   da;
    logic [32:0]   da_abs;
    logic [31:0]   dn_cur;
    logic          slot_free;
    plu_div_req_t  div_req;
    plu_div_rsp_t  div_rsp;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign wr_en     = accept && (req.operation == OP_LOAD)
                       && (count_reg < CW'(TABLE_DEPTH));
    assign cur_t     = rd_data[63:32];
    assign cur_a     = rd_data[31:0];
    assign cnt_m1    = count_reg - CW'(1);
    assign last_idx  = cnt_m1[AW-1:0];
    assign da        = {cur_a[31], cur_a} - {prev_a_reg[31], prev_a_reg};
    assign da_abs    = da[32] ? (33'd0 - da) : da;
    assign dn_cur    = cur_t - prev_t_reg;
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (state_reg)
            S_FIRST: rd_addr = last_idx;
            S_LAST:  rd_addr = AW'(1);
            S_WALK:  rd_addr = idx_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    plu_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({req.point_time, req.point_amplitude}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign div_req.start    = (state_reg == S_MUL);
    assign div_req.dividend = {32'd0, mag_reg} * {32'd0, dt_reg};
    assign div_req.divisor  = dn_reg;

    plu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        qtime_next      = qtime_reg;
        prev_t_next     = prev_t_reg;
        prev_a_next     = prev_a_reg;
        mag_next        = mag_reg;
        dt_next         = dt_reg;
        dn_next         = dn_reg;
        neg_next        = neg_reg;
        res_amp_next    = res_amp_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_amp_next    = out_amp_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qtime_next      = req.point_time;
                    res_amp_next    = '0;
                    res_status_next = STATUS_OK;
                    state_next      = S_RESULT;
                    if (req.operation == OP_LOAD)
                    begin
                        if (wr_en)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            res_status_next = STATUS_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                prev_t_next = cur_t;
                prev_a_next = cur_a;
                if (qtime_reg <= cur_t)
                begin
                    res_amp_next = cur_a;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                idx_next = AW'(1);
                if (qtime_reg >= cur_t)
                begin
                    res_amp_next = cur_a;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (qtime_reg >= prev_t_reg && qtime_reg <= cur_t)
                begin
                    if (dn_cur == '0)
                    begin
                        res_amp_next = prev_a_reg;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        dn_next    = dn_cur;
                        dt_next    = qtime_reg - prev_t_reg;
                        mag_next   = da_abs[31:0];
                        neg_next   = da[32];
                        state_next = S_MUL;
                    end
                end
                else if (idx_reg == last_idx)
                begin
                    res_amp_next = '0;
                    state_next   = S_RESULT;
                end
                else
                begin
                    prev_t_next = cur_t;
                    prev_a_next = cur_a;
                    idx_next    = idx_reg + AW'(1);
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_amp_next = neg_reg ? (prev_a_reg - div_rsp.quotient)
                                           : (prev_a_reg + div_rsp.quotient);
                    state_next   = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_amp_next    = res_amp_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        qtime_reg      <= qtime_next;
        prev_t_reg     <= prev_t_next;
        prev_a_reg     <= prev_a_next;
        mag_reg        <= mag_next;
        dt_reg         <= dt_next;
        dn_reg         <= dn_next;
        neg_reg        <= neg_next;
        res_amp_reg    <= res_amp_next;
        res_status_reg <= res_status_next;
        out_amp_reg    <= out_amp_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.amplitude_out = out_amp_reg;
    assign rsp.status        = out_status_reg;

endmodule

// ----- rtl/plu_checker.sv -----
// port-level checks for the interpolator, bound to the top level
// depends on plu_pkg and piecewise_linear_interpolator_unit

module plu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] amplitude_out,
    input logic [1:0]  status
);
    import plu_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(amplitude_out) && $stable(status))
    else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready held after a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_EMPTY || status == STATUS_FULL)
    else $error("bad status code");

    // errors carry zero amplitude
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> amplitude_out == 32'd0)
    else $error("error result with non-zero amplitude");

endmodule

bind piecewise_linear_interpolator_unit plu_checker u_plu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .amplitude_out (rsp.amplitude_out),
    .status        (rsp.status)
);
